### hdl/wra_pkg.sv
package wra_pkg;

    // Field widths
    localparam int TIME_W     = 32;
    localparam int VAL_W      = 48;
    localparam int METHOD_W   = 3;
    localparam int STEP_W     = 32;
    localparam int FILL_W     = 17;
    localparam int FRAC_W     = 16;
    localparam int OUT_CNT_W  = 11;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 32;

    // Default slot capacity of one window
    localparam int DEF_MAX_SLOTS = 1024;

    // Combine rules; codes above LAST behave as sum
    localparam logic [METHOD_W-1:0] METH_AVG  = 3'd0;
    localparam logic [METHOD_W-1:0] METH_SUM  = 3'd1;
    localparam logic [METHOD_W-1:0] METH_MIN  = 3'd2;
    localparam logic [METHOD_W-1:0] METH_MAX  = 3'd3;
    localparam logic [METHOD_W-1:0] METH_LAST = 3'd4;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_METHOD = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_STEP   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_FILL   = 2'd2;

    // Register reset values
    localparam logic [METHOD_W-1:0] RST_METHOD = METH_AVG;
    localparam logic [STEP_W-1:0]   RST_STEP   = 32'd60;
    localparam logic [FILL_W-1:0]   RST_FILL   = 17'd32768;

    // Saturation limits of the signed Q31.16 value
    localparam logic signed [VAL_W-1:0] VAL_MAX = {1'b0, {(VAL_W-1){1'b1}}};
    localparam logic signed [VAL_W-1:0] VAL_MIN = {1'b1, {(VAL_W-1){1'b0}}};

    typedef struct packed {
        logic [TIME_W-1:0]       slot_time;
        logic signed [VAL_W-1:0] slot_value;
        logic [TIME_W-1:0]       window_start;
        logic                    first_slot;
        logic                    last_slot;
    } wra_in_t;

    typedef struct packed {
        logic signed [VAL_W-1:0] aggregate_value;
        logic [OUT_CNT_W-1:0]    known_slots;
        logic [OUT_CNT_W-1:0]    total_slots;
        logic                    accepted;
        logic [TIME_W-1:0]       coarse_time;
        logic                    saturated;
    } wra_out_t;

    // Controller to datapath
    typedef struct packed {
        logic take;
        logic finish;
        logic div_start;
        logic load;
    } wra_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic need_div;
        logic div_done;
        logic out_free;
    } wra_sts_t;

endpackage

### hdl/wra_div.sv
module wra_div #(
    parameter int DW = wra_pkg::VAL_W,
    parameter int VW = 11
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 start,
    input  logic signed [DW-1:0] dividend,
    input  logic [VW-1:0]        divisor,
    output logic                 done,
    output logic signed [DW-1:0] quotient
);
    localparam int IW = (DW > 1) ? $clog2(DW) : 1;

    logic          busy_reg, busy_next;
    logic [IW-1:0] iter_reg, iter_next;
    logic [DW-1:0] quo_reg, quo_next;
    logic [VW-1:0] rem_reg, rem_next;
    logic [VW-1:0] dvs_reg;
    logic          neg_reg;
    logic [VW:0]   trial;
    logic [VW:0]   diff;
    logic          fits;

    // One quotient bit per cycle, restoring form on magnitudes
    always_comb begin
        trial     = {rem_reg, quo_reg[DW-1]};
        diff      = trial - {1'b0, dvs_reg};
        fits      = (trial >= {1'b0, dvs_reg});
        busy_next = busy_reg;
        iter_next = iter_reg;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        if (start) begin
            busy_next = 1'b1;
            iter_next = IW'(DW - 1);
            quo_next  = dividend[DW-1] ? (~dividend + 1'b1) : dividend;
            rem_next  = '0;
        end else if (busy_reg) begin
            quo_next  = {quo_reg[DW-2:0], fits};
            rem_next  = fits ? diff[VW-1:0] : trial[VW-1:0];
            iter_next = iter_reg - 1'b1;
            if (iter_reg == '0) begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            iter_reg <= '0;
        end else begin
            busy_reg <= busy_next;
            iter_reg <= iter_next;
        end
    end

    // Operands and partial results
    always_ff @(posedge aclk) begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        if (start) begin
            dvs_reg <= divisor;
            neg_reg <= dividend[DW-1];
        end
    end

    assign done     = busy_reg && (iter_reg == '0);
    assign quotient = neg_reg ? -$signed(quo_reg) : $signed(quo_reg);

endmodule

### hdl/wra_dpath.sv
module wra_dpath #(
    parameter int MAX_SLOTS = wra_pkg::DEF_MAX_SLOTS
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           cfg_valid,
    input  logic [wra_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [wra_pkg::CFG_DATA_W-1:0] cfg_data,
    input  wra_pkg::wra_in_t               s_data,
    input  wra_pkg::wra_cmd_t              cmd,
    output wra_pkg::wra_sts_t              sts,
    output logic                           m_valid,
    input  logic                           m_ready,
    output wra_pkg::wra_out_t              m_data
);
    import wra_pkg::*;

    localparam int CNT_W  = $clog2(MAX_SLOTS + 1);
    localparam int PROD_W = FILL_W + CNT_W;

    logic [METHOD_W-1:0]     method_reg;
    logic [STEP_W-1:0]       step_reg;
    logic [FILL_W-1:0]       fill_reg;

    logic [TIME_W-1:0]       exp_reg, exp_next;
    logic [TIME_W-1:0]       base_reg, base_next;
    logic signed [VAL_W-1:0] acc_reg, acc_next;
    logic [CNT_W-1:0]        known_reg, known_next;
    logic [CNT_W-1:0]        slot_reg, slot_next;
    logic                    ovf_reg, ovf_next;

    logic [TIME_W-1:0]       exp_e;
    logic signed [VAL_W-1:0] acc_e;
    logic [CNT_W-1:0]        known_e;
    logic [CNT_W-1:0]        slot_e;
    logic                    ovf_e;
    logic signed [VAL_W-1:0] val;
    logic signed [VAL_W:0]   sum_w;

    logic [PROD_W-1:0]       prod_reg;
    logic [PROD_W-1:0]       need_lhs;
    logic signed [VAL_W-1:0] quotient;
    logic signed [VAL_W-1:0] agg;

    logic                    m_valid_reg;
    wra_out_t                m_data_reg;

    // Configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            method_reg <= RST_METHOD;
            step_reg   <= RST_STEP;
            fill_reg   <= RST_FILL;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                CFG_METHOD: method_reg <= cfg_data[METHOD_W-1:0];
                CFG_STEP:   step_reg   <= cfg_data[STEP_W-1:0];
                CFG_FILL:   fill_reg   <= cfg_data[FILL_W-1:0];
                default:    ;
            endcase
        end
    end

    // Fold one slot beat into the window
    always_comb begin
        val        = s_data.slot_value;
        exp_e      = s_data.first_slot ? s_data.window_start : exp_reg;
        base_next  = s_data.first_slot ? s_data.window_start : base_reg;
        acc_e      = s_data.first_slot ? '0 : acc_reg;
        known_e    = s_data.first_slot ? '0 : known_reg;
        slot_e     = s_data.first_slot ? '0 : slot_reg;
        ovf_e      = s_data.first_slot ? 1'b0 : ovf_reg;
        sum_w      = {acc_e[VAL_W-1], acc_e} + {val[VAL_W-1], val};
        acc_next   = acc_e;
        known_next = known_e;
        slot_next  = slot_e;
        ovf_next   = ovf_e;
        if (slot_e >= CNT_W'(MAX_SLOTS)) begin
            ovf_next = 1'b1;
        end else begin
            slot_next = slot_e + 1'b1;
            if (s_data.slot_time == exp_e) begin
                known_next = known_e + 1'b1;
                if (known_e == '0) begin
                    acc_next = val;
                end else begin
                    unique case (method_reg)
                        METH_MIN:  acc_next = (val < acc_e) ? val : acc_e;
                        METH_MAX:  acc_next = (val > acc_e) ? val : acc_e;
                        METH_LAST: acc_next = val;
                        default: begin
                            // saturate the running sum
                            if (sum_w[VAL_W] != sum_w[VAL_W-1]) begin
                                acc_next = sum_w[VAL_W] ? VAL_MIN : VAL_MAX;
                                ovf_next = 1'b1;
                            end else begin
                                acc_next = sum_w[VAL_W-1:0];
                            end
                        end
                    endcase
                end
            end
        end
        exp_next = exp_e + step_reg;
    end

    // Window state: advance on a slot beat, clear once the result is loaded
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            exp_reg   <= '0;
            base_reg  <= '0;
            acc_reg   <= '0;
            known_reg <= '0;
            slot_reg  <= '0;
            ovf_reg   <= 1'b0;
        end else if (cmd.take) begin
            exp_reg   <= exp_next;
            base_reg  <= base_next;
            acc_reg   <= acc_next;
            known_reg <= known_next;
            slot_reg  <= slot_next;
            ovf_reg   <= ovf_next;
        end else if (cmd.load) begin
            acc_reg   <= '0;
            known_reg <= '0;
            slot_reg  <= '0;
            ovf_reg   <= 1'b0;
        end
    end

    // Required known count, scaled by one in Q1.16
    always_ff @(posedge aclk) begin
        if (cmd.finish) begin
            prod_reg <= PROD_W'(fill_reg) * PROD_W'(slot_reg);
        end
    end

    // Average division
    wra_div #(
        .DW (VAL_W),
        .VW (CNT_W)
    ) u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (cmd.div_start),
        .dividend (acc_reg),
        .divisor  (known_reg),
        .done     (sts.div_done),
        .quotient (quotient)
    );

    assign sts.need_div = (method_reg == METH_AVG) && (known_reg != '0);
    assign sts.out_free = !m_valid_reg || m_ready;

    // Pick the aggregate of the closed window
    always_comb begin
        need_lhs = PROD_W'(known_reg) << FRAC_W;
        if (known_reg == '0) begin
            agg = '0;
        end else if (method_reg == METH_AVG) begin
            agg = quotient;
        end else begin
            agg = acc_reg;
        end
    end

    // Result register: hold until the beat is taken
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.load) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            m_data_reg.aggregate_value <= agg;
            m_data_reg.known_slots     <= OUT_CNT_W'(known_reg);
            m_data_reg.total_slots     <= OUT_CNT_W'(slot_reg);
            m_data_reg.accepted        <= (need_lhs >= prod_reg);
            m_data_reg.coarse_time     <= base_reg;
            m_data_reg.saturated       <= ovf_reg;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

`ifndef SYNTHESIS
    a_known_le_slots: assert property (@(posedge aclk) disable iff (!aresetn)
        known_reg <= slot_reg)
        else $error("known count exceeds slot count");

    a_slot_capped: assert property (@(posedge aclk) disable iff (!aresetn)
        slot_reg <= CNT_W'(MAX_SLOTS))
        else $error("slot count beyond capacity");

    a_load_shows: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.load |=> m_valid_reg)
        else $error("loaded result not presented");
`endif

endmodule

### hdl/wra_ctrl.sv
module wra_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    input  logic              s_last,
    output logic              s_ready,
    input  wra_pkg::wra_sts_t sts,
    output wra_pkg::wra_cmd_t cmd
);
    import wra_pkg::*;

    typedef enum logic [1:0] {
        ST_RUN,
        ST_FINISH,
        ST_DIVIDE,
        ST_EMIT
    } state_t;

    state_t state_reg;
    logic   s_ready_reg;

    // Commands from the current state
    always_comb begin
        cmd.take      = s_valid && s_ready_reg;
        cmd.finish    = (state_reg == ST_FINISH);
        cmd.div_start = (state_reg == ST_FINISH) && sts.need_div;
        cmd.load      = (state_reg == ST_EMIT) && sts.out_free;
    end

    // Stream slots, then close the window and hand over the result
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_RUN;
            s_ready_reg <= 1'b1;
        end else begin
            unique case (state_reg)
                ST_RUN: begin
                    if (s_valid && s_ready_reg && s_last) begin
                        state_reg   <= ST_FINISH;
                        s_ready_reg <= 1'b0;
                    end
                end
                ST_FINISH: begin
                    state_reg <= sts.need_div ? ST_DIVIDE : ST_EMIT;
                end
                ST_DIVIDE: begin
                    if (sts.div_done) begin
                        state_reg <= ST_EMIT;
                    end
                end
                ST_EMIT: begin
                    if (sts.out_free) begin
                        state_reg   <= ST_RUN;
                        s_ready_reg <= 1'b1;
                    end
                end
                default: begin
                    state_reg   <= ST_RUN;
                    s_ready_reg <= 1'b1;
                end
            endcase
        end
    end

    assign s_ready = s_ready_reg;

`ifndef SYNTHESIS
    a_ready_in_run: assert property (@(posedge aclk) disable iff (!aresetn)
        s_ready_reg |-> state_reg == ST_RUN)
        else $error("slot input open outside streaming");

    a_done_in_divide: assert property (@(posedge aclk) disable iff (!aresetn)
        sts.div_done |-> state_reg == ST_DIVIDE)
        else $error("divider finished outside divide state");
`endif

endmodule

### hdl/window_rollup_aggregator_unit.sv
// Channel  Direction  Handshake                Payload
// s_       in         s_valid / s_ready        s_data    (wra_in_t, one slot)
// m_       out        m_valid / m_ready        m_data    (wra_out_t, one coarse point)
// cfg_     in         cfg_valid / cfg_ready    cfg_index, cfg_data
//
// Slots that do not close their window stream back to back. Closing a window passes
// the finish state, the divide state for an average with known slots, and the emit
// state; the serial divider produces one quotient bit per cycle over the 48-bit value.
// While the result register is full, the close waits until m_ready frees it.
// Synchronous active-low reset; the block takes slots from the first cycle after reset.
module window_rollup_aggregator_unit #(
    parameter int MAX_SLOTS = wra_pkg::DEF_MAX_SLOTS
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [wra_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [wra_pkg::CFG_DATA_W-1:0] cfg_data,
    input  logic                           s_valid,
    output logic                           s_ready,
    input  wra_pkg::wra_in_t               s_data,
    output logic                           m_valid,
    input  logic                           m_ready,
    output wra_pkg::wra_out_t              m_data
);
    import wra_pkg::*;

    wra_cmd_t cmd;
    wra_sts_t sts;

    // Registers accept a write every cycle
    assign cfg_ready = 1'b1;

    wra_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_last  (s_data.last_slot),
        .s_ready (s_ready),
        .sts     (sts),
        .cmd     (cmd)
    );

    wra_dpath #(
        .MAX_SLOTS (MAX_SLOTS)
    ) u_dpath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_data    (s_data),
        .cmd       (cmd),
        .sts       (sts),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

endmodule
